// ----- rtl/frp_pkg.sv -----
// Shared types and constants for the fragment relocation patcher.
package frp_pkg;

    // Item function codes
    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_RELOC = 1'b1;

    // Relocation kinds (ELF MIPS numbering)
    localparam logic [6:0] KIND_WORD = 7'd2;
    localparam logic [6:0] KIND_JUMP = 7'd4;
    localparam logic [6:0] KIND_HI16 = 7'd5;
    localparam logic [6:0] KIND_LO16 = 7'd6;

    // HI16 register slots
    localparam int unsigned REG_SLOTS = 32;
    localparam int unsigned SLOT_W    = 5;

    // Front-to-back queue
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = 1;
    localparam int unsigned QCNT_W      = 2;

    // Mapped address window and fragment numbering
    localparam logic [3:0] WIN_SEG    = 4'h8;
    localparam logic [7:0] FRAG_FIRST = 8'h10;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_JUMP,
        OP_LO16
    } op_t;

    // Work handed from the front to the back
    typedef struct packed {
        op_t         op;
        logic [31:0] addr;
        logic        hit;
        logic [31:0] base;
        logic [23:0] offset;
        logic [31:0] word;
        logic [23:0] slot_offset;
        logic [31:0] slot_word;
    } work_t;

    // One output patch
    typedef struct packed {
        logic [23:0] offset;
        logic [31:0] word;
        logic        last;
    } beat_t;

endpackage

// ----- rtl/frp_if.sv -----
// Channel interfaces: relocation items in, patches out.
interface frp_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  entry_id;
    logic [31:0] base_addr;
    logic [6:0]  reloc_kind;
    logic [23:0] target_offset;
    logic [31:0] target_word;

    modport source (
        output valid, func, entry_id, base_addr, reloc_kind, target_offset, target_word,
        input  ready
    );
    modport sink (
        input  valid, func, entry_id, base_addr, reloc_kind, target_offset, target_word,
        output ready
    );
endinterface

interface frp_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] patch_offset;
    logic [31:0] patch_word;
    logic        last_patch;

    modport source (
        output valid, patch_offset, patch_word, last_patch,
        input  ready
    );
    modport sink (
        input  valid, patch_offset, patch_word, last_patch,
        output ready
    );
endinterface

// ----- rtl/fragment_relocation_patcher_unit.sv -----
// Fragment relocation patcher: takes one item per clock cycle when the output
// side keeps up. Word and jump relocations give one patch beat, LO16 gives two
// beats (the LUI word, then the low word) and holds the patch issue stage while
// the second beat waits; set items, HI16 and unknown kinds give none. The first
// beat of an item passes the input register, fragment table read, queue and
// output register; a two-entry queue lets the front keep taking items while the
// back stalls. The fragment table clears at reset through per-entry valid bits,
// so there is no clearing pass. A LO16 must follow a HI16 that filled its slot.
module fragment_relocation_patcher_unit #(
    parameter int unsigned FRAGMENT_ENTRIES = 240
) (
    input  logic      clk,
    input  logic      rst_n,
    frp_in_if.sink    rel_in,
    frp_out_if.source patch_out
);

    logic           push_valid;
    logic           push_ready;
    frp_pkg::work_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    frp_pkg::work_t pop_data;

    frp_front #(
        .FRAGMENT_ENTRIES (FRAGMENT_ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rel_in     (rel_in),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    frp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    frp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .patch_out (patch_out)
    );

endmodule

// ----- rtl/frp_front.sv -----
// Front: accepts items, keeps HI16 slots and the fragment table, forms addresses.
module frp_front #(
    parameter int unsigned FRAGMENT_ENTRIES = 240
) (
    input  logic            clk,
    input  logic            rst_n,
    frp_in_if.sink          rel_in,
    output logic            push_valid,
    output frp_pkg::work_t  push_data,
    input  logic            push_ready
);

    localparam int unsigned IDX_W      = (FRAGMENT_ENTRIES > 1) ? $clog2(FRAGMENT_ENTRIES) : 1;
    localparam logic [7:0]  FRAG_LIMIT = 8'(FRAGMENT_ENTRIES);

    // Slot storage
    logic [23:0] slot_off_mem [frp_pkg::REG_SLOTS];
    logic [31:0] slot_word_mem [frp_pkg::REG_SLOTS];

    // Fragment table and its valid bits
    logic [31:0]                 base_mem [FRAGMENT_ENTRIES];
    logic [FRAGMENT_ENTRIES-1:0] map_valid_reg;

    // Stage 1
    logic        s1_valid_reg;
    logic        s1_func_reg;
    logic [7:0]  s1_entry_reg;
    logic [31:0] s1_base_reg;
    logic [6:0]  s1_kind_reg;
    logic [23:0] s1_off_reg;
    logic [31:0] s1_word_reg;
    logic [23:0] s1_slot_off_reg;
    logic [31:0] s1_slot_word_reg;

    // Stage 2
    logic        s2_valid_reg;
    frp_pkg::op_t s2_op_reg;
    logic [31:0] s2_addr_reg;
    logic [23:0] s2_off_reg;
    logic [31:0] s2_word_reg;
    logic [23:0] s2_slot_off_reg;
    logic [31:0] s2_slot_word_reg;
    logic [31:0] s2_base_reg;
    logic        s2_hit_reg;

    logic               acc;
    logic               adv1;
    logic               s2_free;
    logic               s1_emits;
    logic               s1_is_set;
    frp_pkg::op_t       s1_op;
    logic [31:0]        s1_addr;
    logic [7:0]         frag;
    logic               in_win;
    logic               in_range;
    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   wr_idx;
    logic               wr_en;
    logic [frp_pkg::SLOT_W-1:0] slot_rd;
    logic [frp_pkg::SLOT_W-1:0] slot_wr;

    // Handshake chain: stage 2 drains into the queue, stage 1 into stage 2
    assign s2_free      = !s2_valid_reg || push_ready;
    assign adv1         = s1_valid_reg && s2_free;
    assign rel_in.ready = !s1_valid_reg || s2_free;
    assign acc          = rel_in.valid && rel_in.ready;
    assign push_valid   = s2_valid_reg;

    assign slot_rd = rel_in.target_word[25:21];
    assign slot_wr = rel_in.target_word[20:16];

    // Classify stage 1 item and form its address
    always_comb
    begin
        s1_is_set = (s1_func_reg == frp_pkg::FUNC_SET);
        s1_emits  = 1'b0;
        s1_op     = frp_pkg::OP_WORD;
        s1_addr   = s1_word_reg;
        if (!s1_is_set)
        begin
            unique case (s1_kind_reg)
                frp_pkg::KIND_WORD:
                begin
                    s1_emits = 1'b1;
                    s1_op    = frp_pkg::OP_WORD;
                    s1_addr  = s1_word_reg;
                end
                frp_pkg::KIND_JUMP:
                begin
                    s1_emits = 1'b1;
                    s1_op    = frp_pkg::OP_JUMP;
                    s1_addr  = {frp_pkg::WIN_SEG, s1_word_reg[25:0], 2'b00};
                end
                frp_pkg::KIND_LO16:
                begin
                    s1_emits = 1'b1;
                    s1_op    = frp_pkg::OP_LO16;
                    s1_addr  = {s1_slot_word_reg[15:0], 16'h0000}
                             + {{16{s1_word_reg[15]}}, s1_word_reg[15:0]};
                end
                default:
                begin
                    s1_emits = 1'b0;
                end
            endcase
        end
    end

    // Fragment number within the mapped window
    assign frag     = s1_addr[27:20] - frp_pkg::FRAG_FIRST;
    assign in_win   = (s1_addr[31:28] == frp_pkg::WIN_SEG) && (s1_addr[27:24] != 4'h0);
    assign in_range = (frag < FRAG_LIMIT);
    assign rd_idx   = frag[IDX_W-1:0];
    assign wr_idx   = s1_entry_reg[IDX_W-1:0];
    assign wr_en    = adv1 && s1_is_set && (s1_entry_reg < FRAG_LIMIT);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            map_valid_reg <= '0;
        end
        else
        begin
            if (acc)
                s1_valid_reg <= 1'b1;
            else if (adv1)
                s1_valid_reg <= 1'b0;

            if (adv1)
                s2_valid_reg <= s1_emits;
            else if (push_ready)
                s2_valid_reg <= 1'b0;

            if (wr_en)
                map_valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Slot memory: HI16 writes and LO16 reads at accept
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_slot_off_reg  <= slot_off_mem[slot_rd];
            s1_slot_word_reg <= slot_word_mem[slot_rd];
            if (rel_in.func == frp_pkg::FUNC_RELOC && rel_in.reloc_kind == frp_pkg::KIND_HI16)
            begin
                slot_off_mem[slot_wr]  <= rel_in.target_offset;
                slot_word_mem[slot_wr] <= rel_in.target_word;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_func_reg  <= rel_in.func;
            s1_entry_reg <= rel_in.entry_id;
            s1_base_reg  <= rel_in.base_addr;
            s1_kind_reg  <= rel_in.reloc_kind;
            s1_off_reg   <= rel_in.target_offset;
            s1_word_reg  <= rel_in.target_word;
        end
    end

    // Fragment table: set items write, relocations read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            base_mem[wr_idx] <= s1_base_reg;
        if (adv1 && s1_emits)
            s2_base_reg <= base_mem[rd_idx];
    end

    // Stage 2 payload
    always_ff @(posedge clk)
    begin
        if (adv1 && s1_emits)
        begin
            s2_op_reg        <= s1_op;
            s2_addr_reg      <= s1_addr;
            s2_off_reg       <= s1_off_reg;
            s2_word_reg      <= s1_word_reg;
            s2_slot_off_reg  <= s1_slot_off_reg;
            s2_slot_word_reg <= s1_slot_word_reg;
            s2_hit_reg       <= in_win && in_range && map_valid_reg[rd_idx];
        end
    end

    always_comb
    begin
        push_data.op          = s2_op_reg;
        push_data.addr        = s2_addr_reg;
        push_data.hit         = s2_hit_reg;
        push_data.base        = s2_base_reg;
        push_data.offset      = s2_off_reg;
        push_data.word        = s2_word_reg;
        push_data.slot_offset = s2_slot_off_reg;
        push_data.slot_word   = s2_slot_word_reg;
    end

endmodule

// ----- rtl/frp_queue.sv -----
// Short FIFO between front and back.
module frp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  frp_pkg::work_t  push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output frp_pkg::work_t  pop_data,
    input  logic            pop_ready
);

    frp_pkg::work_t               mem [frp_pkg::QUEUE_DEPTH];
    logic [frp_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [frp_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [frp_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != frp_pkg::QCNT_W'(frp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- rtl/frp_back.sv -----
// Back: translates addresses and issues one patch beat per cycle while the patch output accepts them.
module frp_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    input  frp_pkg::work_t  pop_data,
    output logic            pop_ready,
    frp_out_if.source       patch_out
);

    logic           out_valid_reg;
    frp_pkg::beat_t out_reg;
    logic           pend_valid_reg;
    frp_pkg::beat_t pend_reg;

    logic           out_load;
    logic           take;
    logic [31:0]    tsum;
    logic [31:0]    t;
    logic [15:0]    hi;
    frp_pkg::beat_t first;
    frp_pkg::beat_t second;
    logic           has_second;

    assign out_load  = !out_valid_reg || patch_out.ready;
    assign pop_ready = out_load && !pend_valid_reg;
    assign take      = pop_valid && pop_ready;

    // Translation through the fragment base
    assign tsum = pop_data.base + {12'h000, pop_data.addr[19:0]};
    assign t    = (pop_data.hit && pop_data.base != 32'h0) ? tsum : pop_data.addr;
    assign hi   = t[31:16] + {15'h0000, t[15]};

    // Build patch beats
    always_comb
    begin
        first      = '0;
        second     = '0;
        has_second = 1'b0;
        unique case (pop_data.op)
            frp_pkg::OP_WORD:
            begin
                first = '{offset: pop_data.offset, word: t, last: 1'b1};
            end
            frp_pkg::OP_JUMP:
            begin
                first = '{offset: pop_data.offset,
                          word: {pop_data.word[31:26], t[27:2]}, last: 1'b1};
            end
            frp_pkg::OP_LO16:
            begin
                first  = '{offset: pop_data.slot_offset,
                           word: {pop_data.slot_word[31:16], hi}, last: 1'b0};
                second = '{offset: pop_data.offset,
                           word: {pop_data.word[31:16], t[15:0]}, last: 1'b1};
                has_second = 1'b1;
            end
            default:
            begin
                first = '{offset: pop_data.offset, word: t, last: 1'b1};
            end
        endcase
    end

    // Output and pending beat control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            if (pend_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg  <= pop_valid;
                pend_valid_reg <= pop_valid && has_second;
            end
        end
    end

    // Beat payloads
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (pend_valid_reg)
                out_reg <= pend_reg;
            else if (take)
            begin
                out_reg  <= first;
                pend_reg <= second;
            end
        end
    end

    assign patch_out.valid        = out_valid_reg;
    assign patch_out.patch_offset = out_reg.offset;
    assign patch_out.patch_word   = out_reg.word;
    assign patch_out.last_patch   = out_reg.last;

endmodule
